@@ rtl/core/phn_pkg.sv @@
package phn_pkg;

  // Operation codes carried in the action field.
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = 8;
  localparam int CNT_OUT_W = 24;
  localparam int FRAC_W    = 17;

  // 1.0 in unsigned Q1.16.
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  typedef struct packed {
    logic [1:0]       action;
    logic [BIN_W-1:0] pixel_value;
    logic [BIN_W-1:0] bin_select;
  } item_t;

  typedef struct packed {
    logic [BIN_W-1:0]     bin_index;
    logic [CNT_OUT_W-1:0] bin_count;
    logic [FRAC_W-1:0]    fraction;
    logic                 empty_flag;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/phn_div.sv @@
module phn_div #(
  parameter int CW = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CW-1:0]                 num,
  input  logic [CW-1:0]                 den,
  input  logic                          take,
  output phn_pkg::div_stat_t            stat,
  output logic [phn_pkg::FRAC_W-1:0]    quot,
  output logic                          empty
);
  import phn_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [CW-1:0]     rem;
  logic [CW-1:0]     dvs;
  logic [FRAC_W-1:0] q;
  logic              zero_den;

  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic              ge;
  logic [CW-1:0]     rem_next;

  // Restoring division. The numerator never exceeds the divisor, so the
  // first step decides the integer bit without a shift and every later
  // step shifts the remainder by one.
  assign trial    = (step == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_RUN;
      ST_RUN:  if (step == LAST_STEP) state_next = ST_DONE;
      ST_DONE: if (take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      rem      <= num;
      dvs      <= den;
      zero_den <= (den == '0);
      step     <= '0;
      q        <= '0;
    end else if (state == ST_RUN) begin
      rem  <= rem_next;
      q    <= {q[FRAC_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_DONE);
  assign empty     = zero_den;
  assign quot      = zero_den ? '0 : (q[FRAC_W-1] ? FRAC_ONE : q);

endmodule

@@ rtl/core/pixel_histogram_normalized.sv @@
// 256-bin histogram of 8-bit pixels with normalized bin readout.
// Input beats arrive on item/item_valid and are held off by item_stall.
// An add beat counts its pixel in one bin and in the running total; both
// counters saturate. A clear beat zeroes every bin and the total. A read
// beat returns one result beat on result/result_valid carrying the bin's
// raw count and floor(count * 65536 / total) in unsigned Q1.16.
// Adds and clears are taken one per cycle while no read is in flight.
// Their read-modify-write runs through a two-stage pipeline around the
// bin memory, which is read in the first stage and written in the second,
// with a forwarding register covering back-to-back hits on the same bin.
// A read needs one memory access and a 17-step restoring divider; its
// result goes through stage 1, stage 2 and the divider into the output
// register once that is free, and item_stall stays high from the cycle
// after a read is taken until the result has moved into the output
// register. Further adds are then taken even while that result waits on
// result_stall; only the next read waits for it.
// Reset clears all bins at once through a per-bin valid vector and empties
// the total, so the block is ready in the first cycle after reset.
// A stalled result beat holds its value until the receiver takes it.
module pixel_histogram_normalized #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  phn_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_stall,
  output phn_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);
  import phn_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    vbits;

  logic                   item_accept;

  logic                   s1_valid;
  logic [1:0]             s1_act;
  logic [BIN_W-1:0]       s1_addr;

  logic                   s2_valid;
  logic [1:0]             s2_act;
  logic [BIN_W-1:0]       s2_addr;
  logic [COUNT_WIDTH-1:0] rdata;

  logic                   fwd_valid;
  logic [BIN_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic [COUNT_WIDTH-1:0] pixel_total;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] cur_inc;
  logic                   s2_add;
  logic                   s2_read;
  logic                   s2_clear;

  logic [BIN_W-1:0]       rd_idx;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [CNT_OUT_W-1:0]   rd_cnt_out;

  div_stat_t              div_stat;
  logic [FRAC_W-1:0]      div_quot;
  logic                   div_empty;
  logic                   out_load;

  // A read in flight holds off new beats until its quotient has moved into the output register.
  assign item_stall  = (s1_valid && s1_act == ACT_READ) ||
                       (s2_valid && s2_act == ACT_READ) || div_stat.busy;
  assign item_accept = item_valid && !item_stall;

  // Stage 1: the memory address is registered with the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= item_accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_act  <= item.action;
      s1_addr <= (item.action == ACT_ADD) ? item.pixel_value : item.bin_select;
    end
    s2_act  <= s1_act;
    s2_addr <= s1_addr;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[s1_addr];
  end

  // Stage 2: the bin value is the last write to the same bin if that write
  // landed while this beat was reading, else the memory word, or zero when
  // the bin has not been written since the last clear.
  assign s2_add   = s2_valid && s2_act == ACT_ADD;
  assign s2_read  = s2_valid && s2_act == ACT_READ;
  assign s2_clear = s2_valid && s2_act == ACT_CLEAR;

  always_comb begin
    if (fwd_valid && fwd_addr == s2_addr) begin
      cur = fwd_data;
    end else if (vbits[s2_addr]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
  end

  assign cur_inc = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  always_ff @(posedge clk) begin
    if (s2_add) begin
      mem[s2_addr] <= cur_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits       <= '0;
      fwd_valid   <= 1'b0;
      pixel_total <= '0;
    end else if (s2_clear) begin
      vbits       <= '0;
      fwd_valid   <= 1'b0;
      pixel_total <= '0;
    end else if (s2_add) begin
      vbits[s2_addr] <= 1'b1;
      fwd_valid      <= 1'b1;
      if (pixel_total != COUNT_MAX) begin
        pixel_total <= pixel_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_add) begin
      fwd_addr <= s2_addr;
      fwd_data <= cur_inc;
    end
    if (s2_read) begin
      rd_idx <= s2_addr;
      rd_cnt <= cur;
    end
  end

  generate
    if (COUNT_WIDTH >= CNT_OUT_W) begin : g_cnt_trunc
      assign rd_cnt_out = rd_cnt[CNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign rd_cnt_out = {{(CNT_OUT_W - COUNT_WIDTH){1'b0}}, rd_cnt};
    end
  endgenerate

  phn_div #(
    .CW (COUNT_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (s2_read),
    .num   (cur),
    .den   (pixel_total),
    .take  (out_load),
    .stat  (div_stat),
    .quot  (div_quot),
    .empty (div_empty)
  );

  // Output register: the finished quotient moves here once the slot is free.
  assign out_load = div_stat.done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.bin_index  <= rd_idx;
      result.bin_count  <= rd_cnt_out;
      result.fraction   <= div_quot;
      result.empty_flag <= div_empty;
    end
  end

  a_div_idle_on_read: assert property (@(posedge clk) disable iff (rst)
    s2_read |-> !div_stat.busy)
    else $error("read reached the divider while it was busy");

  a_clear_empties_total: assert property (@(posedge clk) disable iff (rst)
    s2_clear |=> (pixel_total == '0 && vbits == '0))
    else $error("clear did not empty the histogram");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    (div_stat.done && !result_valid) |=> (result_valid && !div_stat.busy))
    else $error("finished divide was not moved to the output");

  a_fraction_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.fraction <= FRAC_ONE &&
                      (!result.empty_flag || result.fraction == '0)))
    else $error("fraction out of range");

  a_total_bounds_bin: assert property (@(posedge clk) disable iff (rst)
    s2_read |-> cur <= pixel_total)
    else $error("bin count exceeds total");

endmodule
